@@ rtl/ps2s1_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the ps/2 set 1 scancode decoder
// no dependencies

package ps2s1_pkg;

  localparam int KEY_SLOTS_DEF = 256;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [7:0] PREFIX_BYTE   = 8'hE0;
  localparam logic [6:0] KEY_CTRL      = 7'h1D;
  localparam logic [6:0] KEY_ALT       = 7'h38;
  localparam logic [6:0] KEY_LSHIFT    = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT    = 7'h36;
  localparam logic [6:0] KEY_CAPS      = 7'h3A;
  localparam logic [6:0] KEY_NUM       = 7'h45;
  localparam logic [6:0] KEY_SCROLL    = 7'h46;
  localparam logic [6:0] KEY_NONE      = 7'h00;
  localparam logic [7:0] EXT_SLOT_BASE = 8'd127;

  localparam logic [5:0] MOD_LSHIFT = 6'b000001;
  localparam logic [5:0] MOD_RSHIFT = 6'b000010;
  localparam logic [5:0] MOD_LCTRL  = 6'b000100;
  localparam logic [5:0] MOD_RCTRL  = 6'b001000;
  localparam logic [5:0] MOD_LALT   = 6'b010000;
  localparam logic [5:0] MOD_RALT   = 6'b100000;

  localparam logic [2:0] LOCK_CAPS   = 3'b001;
  localparam logic [2:0] LOCK_NUM    = 3'b010;
  localparam logic [2:0] LOCK_SCROLL = 3'b100;

  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_LOWER = 2'd1,
    SEL_UPPER = 2'd2,
    SEL_EXT   = 2'd3
  } map_sel_t;

  typedef struct packed {
    logic       en;
    logic [7:0] slot;
    logic       value;
  } key_wr_t;

  typedef struct packed {
    map_sel_t   map_select;
    logic [6:0] map_index;
    logic       slot_written;
    logic [7:0] key_slot;
    logic       slot_value;
    logic [5:0] modifiers;
    logic [2:0] lock_bits;
    logic       prefix_pending;
  } result_t;

endpackage

@@ rtl/ps2s1_keymap.sv @@
`timescale 1ns / 1ps
// key-down map: one-bit synchronous memory with a clearing sweep after reset
// depends on ps2s1_pkg

module ps2s1_keymap
  import ps2s1_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  key_wr_t    wr,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic       rd_data,
  output logic       clearing
);

  localparam int AW = $clog2(KEY_SLOTS);

  logic          mem [KEY_SLOTS];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(KEY_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr.en) begin
      mem[AW'(wr.slot)] <= wr.value;
    end
    if (rd_en) begin
      rd_data <= mem[AW'(rd_addr)];
    end
  end

endmodule

@@ rtl/ps2s1_decode.sv @@
`timescale 1ns / 1ps
// scancode decode: prefix, modifier and lock flags, key-down map write request
// depends on ps2s1_pkg

module ps2s1_decode
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       command,
  input  logic [7:0] scan_byte,
  output result_t    res,
  output key_wr_t    wr
);

  logic       prefix;
  logic [5:0] mods;
  logic [2:0] locks;
  logic       prefix_next;
  logic [5:0] mods_next;
  logic [2:0] locks_next;

  logic       brk;
  logic [6:0] k;
  logic [5:0] mbit;
  logic       wr_en;

  assign brk = scan_byte[7];
  assign k   = scan_byte[6:0];

  always_comb begin
    prefix_next    = prefix;
    mods_next      = mods;
    locks_next     = locks;
    mbit           = '0;
    wr_en          = 1'b0;
    res.map_select = SEL_NONE;
    res.map_index  = '0;
    res.key_slot   = '0;
    res.slot_value = 1'b0;
    if (command == CMD_SCAN) begin
      if (scan_byte == PREFIX_BYTE) begin
        prefix_next = 1'b1;
      end else begin
        if (prefix) begin
          if (k == KEY_CTRL) begin
            mbit = MOD_RCTRL;
          end else if (k == KEY_ALT) begin
            mbit = MOD_RALT;
          end else if (k != KEY_NONE) begin
            if (!brk) begin
              res.map_select = SEL_EXT;
              res.map_index  = k - 7'd1;
            end
            wr_en          = 1'b1;
            res.key_slot   = {1'b0, k} + EXT_SLOT_BASE;
            res.slot_value = !brk;
          end
          prefix_next = 1'b0;
        end else begin
          if (k == KEY_CTRL) begin
            mbit = MOD_LCTRL;
          end else if (k == KEY_LSHIFT) begin
            mbit = MOD_LSHIFT;
          end else if (k == KEY_RSHIFT) begin
            mbit = MOD_RSHIFT;
          end else if (k == KEY_ALT) begin
            mbit = MOD_LALT;
          end else if (k == KEY_CAPS) begin
            if (!brk) locks_next = locks ^ LOCK_CAPS;
          end else if (k == KEY_NUM) begin
            if (!brk) locks_next = locks ^ LOCK_NUM;
          end else if (k == KEY_SCROLL) begin
            if (!brk) locks_next = locks ^ LOCK_SCROLL;
          end else if (k != KEY_NONE) begin
            if (!brk) begin
              res.map_select = ((mods & (MOD_LSHIFT | MOD_RSHIFT)) != '0) ?
                               SEL_UPPER : SEL_LOWER;
              res.map_index  = k - 7'd1;
            end
            wr_en          = 1'b1;
            res.key_slot   = {1'b0, k - 7'd1};
            res.slot_value = !brk;
          end
        end
        if (brk) begin
          mods_next = mods & ~mbit;
        end else begin
          mods_next = mods | mbit;
        end
      end
    end
    res.slot_written   = wr_en;
    res.modifiers      = mods_next;
    res.lock_bits      = locks_next;
    res.prefix_pending = prefix_next;
    wr.en    = accept && wr_en;
    wr.slot  = res.key_slot;
    wr.value = res.slot_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 1'b0;
      mods   <= '0;
      locks  <= '0;
    end else if (accept) begin
      prefix <= prefix_next;
      mods   <= mods_next;
      locks  <= locks_next;
    end
  end

endmodule

@@ rtl/ps2s1_scancode_decoder_top.sv @@
`timescale 1ns / 1ps
// top level of the ps/2 set 1 scancode decoder
// depends on ps2s1_pkg, ps2s1_decode, ps2s1_keymap
//
// usage:
// - input channel (in_valid / in_stall) carries command, scan_byte, query_key;
//   command 0 decodes scan_byte, command 1 reads the key-down map at query_key
// - output channel (out_valid / out_stall) returns one result per transaction
// - each input transaction is registered in the decode stage and then in the output
//   register before its output transaction; one transaction per cycle is
//   taken while the receiver keeps up and the map is not being cleared
// - the map lives in a one-bit memory with a registered read; a scancode writes
//   it in the cycle it is taken, so a following query sees the new value
// - after reset the map is swept to zero across all KEY_SLOTS slots (256 by
//   default), with in_stall high; flags clear at once
// - a stalled receiver holds the output register; one more result waits in
//   the decode stage, after which in_stall rises until the output drains
// - in_stall follows out_stall combinationally once both stages are full;
//   valid never follows stall

module ps2_set1_scancode_decoder
  import ps2s1_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] scan_byte,
  input  logic [7:0] query_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] map_select,
  output logic [6:0] map_index,
  output logic       slot_written,
  output logic [7:0] key_slot,
  output logic       slot_value,
  output logic [5:0] modifiers,
  output logic [2:0] lock_bits,
  output logic       prefix_pending,
  output logic       query_down
);

  logic    in_accept;
  logic    s1_adv;
  logic    s1_valid;
  logic    s1_query;
  result_t s1_res;
  result_t o_res;
  logic    o_query_down;
  result_t dec_res;
  key_wr_t dec_wr;
  logic    rd_data;
  logic    clearing;

  assign in_accept = in_valid && !in_stall;
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = clearing || (s1_valid && !s1_adv);

  ps2s1_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .command   (command),
    .scan_byte (scan_byte),
    .res       (dec_res),
    .wr        (dec_wr)
  );

  ps2s1_keymap #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_keymap (
    .clk      (clk),
    .rst      (rst),
    .wr       (dec_wr),
    .rd_en    (in_accept && (command == CMD_QUERY)),
    .rd_addr  (query_key),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res   <= dec_res;
      s1_query <= (command == CMD_QUERY);
    end
    if (s1_adv) begin
      o_res        <= s1_res;
      o_query_down <= s1_query && rd_data;
    end
  end

  assign map_select     = o_res.map_select;
  assign map_index      = o_res.map_index;
  assign slot_written   = o_res.slot_written;
  assign key_slot       = o_res.key_slot;
  assign slot_value     = o_res.slot_value;
  assign modifiers      = o_res.modifiers;
  assign lock_bits      = o_res.lock_bits;
  assign prefix_pending = o_res.prefix_pending;
  assign query_down     = o_query_down;

endmodule

@@ sim/ps2_set1_scancode_decoder_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for ps2_set1_scancode_decoder: directed and random scancode
// streams under random valid/stall idling, checked against an in-bench decoder model
// depends on ps2s1_pkg and the decoder rtl

import ps2s1_pkg::*;

typedef struct packed {
  map_sel_t   map_select;
  logic [6:0] map_index;
  logic       slot_written;
  logic [7:0] key_slot;
  logic       slot_value;
  logic [5:0] modifiers;
  logic [2:0] lock_bits;
  logic       prefix_pending;
  logic       query_down;
} decoded_key_t;

class keyboard_scoreboard;
  logic         ext_pending;
  logic [5:0]   held_mods;
  logic [2:0]   lock_state;
  logic [255:0] key_down;
  decoded_key_t decoded_q[$];
  int           errors;

  function new();
    ext_pending = 1'b0;
    held_mods   = '0;
    lock_state  = '0;
    key_down    = '0;
    errors      = 0;
  endfunction

  function int pending();
    return decoded_q.size();
  endfunction

  // decode one accepted transaction and queue the expected result
  function void note_input(logic cmd, logic [7:0] sbyte, logic [7:0] qkey);
    decoded_key_t e;
    logic         brk;
    logic [6:0]   k;
    logic [5:0]   mbit;
    e    = '0;
    brk  = sbyte[7];
    k    = sbyte[6:0];
    mbit = '0;
    if (cmd == CMD_QUERY) begin
      e.query_down = key_down[qkey];
    end else if (sbyte == PREFIX_BYTE) begin
      ext_pending = 1'b1;
    end else begin
      if (ext_pending) begin
        if (k == KEY_CTRL) begin
          mbit = MOD_RCTRL;
        end else if (k == KEY_ALT) begin
          mbit = MOD_RALT;
        end else if (k != KEY_NONE) begin
          if (!brk) begin
            e.map_select = SEL_EXT;
            e.map_index  = k - 7'd1;
          end
          e.slot_written = 1'b1;
          e.key_slot     = {1'b0, k} + EXT_SLOT_BASE;
          e.slot_value   = !brk;
        end
        ext_pending = 1'b0;
      end else begin
        if (k == KEY_CTRL) begin
          mbit = MOD_LCTRL;
        end else if (k == KEY_LSHIFT) begin
          mbit = MOD_LSHIFT;
        end else if (k == KEY_RSHIFT) begin
          mbit = MOD_RSHIFT;
        end else if (k == KEY_ALT) begin
          mbit = MOD_LALT;
        end else if (k == KEY_CAPS || k == KEY_NUM || k == KEY_SCROLL) begin
          if (!brk) begin
            if (k == KEY_CAPS) lock_state = lock_state ^ LOCK_CAPS;
            else if (k == KEY_NUM) lock_state = lock_state ^ LOCK_NUM;
            else lock_state = lock_state ^ LOCK_SCROLL;
          end
        end else if (k != KEY_NONE) begin
          if (!brk) begin
            e.map_select = ((held_mods & (MOD_LSHIFT | MOD_RSHIFT)) != 0) ? SEL_UPPER
                                                                         : SEL_LOWER;
            e.map_index  = k - 7'd1;
          end
          e.slot_written = 1'b1;
          e.key_slot     = {1'b0, k - 7'd1};
          e.slot_value   = !brk;
        end
      end
      if (mbit != 0) begin
        if (brk) held_mods = held_mods & ~mbit;
        else held_mods = held_mods | mbit;
      end
      if (e.slot_written) key_down[e.key_slot] = e.slot_value;
    end
    e.modifiers      = held_mods;
    e.lock_bits      = lock_state;
    e.prefix_pending = ext_pending;
    decoded_q.push_back(e);
  endfunction

  function void check_result(decoded_key_t a);
    decoded_key_t e;
    if (decoded_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("error: result with nothing expected: sel %0d idx %0d", a.map_select,
                 a.map_index);
      return;
    end
    e = decoded_q.pop_front();
    if (a.map_select !== e.map_select || a.map_index !== e.map_index ||
        a.slot_written !== e.slot_written || a.key_slot !== e.key_slot ||
        a.slot_value !== e.slot_value || a.modifiers !== e.modifiers ||
        a.lock_bits !== e.lock_bits || a.prefix_pending !== e.prefix_pending ||
        a.query_down !== e.query_down) begin
      errors++;
      if (errors <= 10) begin
        $display({"error: expected sel %0d idx %0d wr %0d slot %0d val %0d",
                  " mods %h locks %h pre %0d q %0d"},
                 e.map_select, e.map_index, e.slot_written, e.key_slot, e.slot_value,
                 e.modifiers, e.lock_bits, e.prefix_pending, e.query_down);
        $display({"       actual   sel %0d idx %0d wr %0d slot %0d val %0d",
                  " mods %h locks %h pre %0d q %0d"},
                 a.map_select, a.map_index, a.slot_written, a.key_slot, a.slot_value,
                 a.modifiers, a.lock_bits, a.prefix_pending, a.query_down);
      end
    end
  endfunction
endclass

module ps2_set1_scancode_decoder_tb;
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       command = CMD_SCAN;
  logic [7:0] scan_byte = '0;
  logic [7:0] query_key = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] map_select;
  logic [6:0] map_index;
  logic       slot_written;
  logic [7:0] key_slot;
  logic       slot_value;
  logic [5:0] modifiers;
  logic [2:0] lock_bits;
  logic       prefix_pending;
  logic       query_down;

  keyboard_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  ps2_set1_scancode_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .scan_byte(scan_byte), .query_key(query_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .map_select(map_select), .map_index(map_index), .slot_written(slot_written),
    .key_slot(key_slot), .slot_value(slot_value), .modifiers(modifiers),
    .lock_bits(lock_bits), .prefix_pending(prefix_pending), .query_down(query_down)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stall, with long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    decoded_key_t act;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        act.map_select     = map_sel_t'(map_select);
        act.map_index      = map_index;
        act.slot_written   = slot_written;
        act.key_slot       = key_slot;
        act.slot_value     = slot_value;
        act.modifiers      = modifiers;
        act.lock_bits      = lock_bits;
        act.prefix_pending = prefix_pending;
        act.query_down     = query_down;
        sb.check_result(act);
      end
    end
  end

  task automatic send(input logic cmd, input logic [7:0] sbyte, input logic [7:0] qkey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    scan_byte <= sbyte;
    query_key <= qkey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, sbyte, qkey);
  endtask

  // random bytes, biased toward modifier and lock keys with a random make/break bit
  function automatic logic [7:0] pick_code();
    logic [6:0] k;
    if ($urandom_range(99) >= 30) return 8'($urandom_range(255));
    case ($urandom_range(7))
      0: k = KEY_CTRL;
      1: k = KEY_ALT;
      2: k = KEY_LSHIFT;
      3: k = KEY_RSHIFT;
      4: k = KEY_CAPS;
      5: k = KEY_NUM;
      6: k = KEY_SCROLL;
      default: k = KEY_NONE;
    endcase
    return {1'($urandom_range(1)), k};
  endfunction

  task automatic run_random(input int n);
    int cnt;
    int r;
    logic [7:0] code;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send(CMD_QUERY, 8'($urandom), 8'($urandom_range(255)));
        cnt++;
      end else if (r < 15) begin
        send(1'($urandom_range(1)), 8'($urandom), 8'($urandom));
        cnt++;
      end else if (r < 35) begin
        send(CMD_SCAN, PREFIX_BYTE, 8'($urandom));
        send(CMD_SCAN, pick_code(), 8'($urandom));
        cnt += 2;
      end else begin
        // key press followed, most of the time, by its release
        code = pick_code();
        send(CMD_SCAN, code, 8'($urandom));
        cnt++;
        if (!code[7] && $urandom_range(99) < 60) begin
          send(CMD_SCAN, {1'b1, code[6:0]}, 8'($urandom));
          cnt++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 11;
    recv_idle_pct = 81;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send(CMD_QUERY, 8'h00, 8'd0);
    send(CMD_SCAN, PREFIX_BYTE, 8'h00);
    send(CMD_SCAN, PREFIX_BYTE, 8'hFF);
    send(CMD_SCAN, {1'b0, KEY_CTRL}, 8'h00);
    send(CMD_SCAN, PREFIX_BYTE, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_ALT}, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_LSHIFT}, 8'h00);
    send(CMD_SCAN, 8'h1E, 8'h00);
    send(CMD_SCAN, {1'b1, KEY_LSHIFT}, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_RSHIFT}, 8'h00);
    send(CMD_SCAN, 8'h01, 8'h00);
    send(CMD_SCAN, {1'b1, KEY_RSHIFT}, 8'h00);
    send(CMD_SCAN, 8'h1E, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_CTRL}, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_ALT}, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_CAPS}, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_NUM}, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_SCROLL}, 8'h00);
    send(CMD_SCAN, {1'b1, KEY_CAPS}, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_NONE}, 8'h00);
    send(CMD_SCAN, {1'b1, KEY_NONE}, 8'h00);
    send(CMD_SCAN, PREFIX_BYTE, 8'h00);
    send(CMD_SCAN, {1'b0, KEY_NONE}, 8'h00);
    send(CMD_SCAN, PREFIX_BYTE, 8'h00);
    send(CMD_SCAN, 8'h7F, 8'h00);
    send(CMD_QUERY, 8'h00, 8'd254);
    send(CMD_SCAN, 8'hFF, 8'h00);
    send(CMD_QUERY, 8'h00, 8'd0);
    send(CMD_QUERY, 8'hFF, 8'd255);

    run_random(390);
    send_idle_pct = 81;
    recv_idle_pct = 11;
    run_random(390);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    run_random(390);
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ps2_set1_scancode_decoder regression: pass");
    end else begin
      $display("ps2_set1_scancode_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ps2_set1_scancode_decoder regression: fail");
    $finish;
  end
endmodule

@@ files.f @@
rtl/ps2s1_pkg.sv
rtl/ps2s1_keymap.sv
rtl/ps2s1_decode.sv
rtl/ps2s1_scancode_decoder_top.sv
sim/ps2_set1_scancode_decoder_tb.sv
